// ===== src/lzssd_pkg.sv =====
// shared types and constants for the lzss ring decompressor
// no dependencies

package lzssd_pkg;

  localparam int WINDOW_SIZE = 4096;
  localparam int RING_AW     = $clog2(WINDOW_SIZE);
  localparam int FILL_W      = RING_AW + 1;
  localparam int CNT_W       = 24;
  localparam int LEN_W       = 5;

  localparam logic [RING_AW-1:0] START_POS   = RING_AW'(WINDOW_SIZE - 18);
  localparam logic [FILL_W-1:0]  FILL_FULL   = FILL_W'(WINDOW_SIZE);
  localparam logic [CNT_W-1:0]   MAX_RESET   = 24'h100000;
  localparam logic [LEN_W-1:0]   LEN_BIAS    = 5'd3;
  localparam logic [3:0]         TOKEN_COUNT = 4'd8;

  typedef enum logic [2:0] {
    PH_FLAG   = 3'b001,
    PH_DATA   = 3'b010,
    PH_MATCH2 = 3'b100
  } phase_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LIT  = 4'b0010,
    S_RD   = 4'b0100,
    S_WR   = 4'b1000
  } state_t;

  // ring access from the sequencer
  typedef struct packed {
    logic               clear;
    logic               rd_en;
    logic [RING_AW-1:0] rd_addr;
    logic               wr_en;
    logic [7:0]         wr_data;
  } ring_cmd_t;

endpackage

// ===== src/lzssd_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies

module lzssd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== src/lzssd_ring.sv =====
// history ring: ram, write pointer and fill count standing in for the per-stream clear
// depends on lzssd_pkg and lzssd_ram

module lzssd_ring
  import lzssd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  ring_cmd_t cmd,
  output logic [7:0] rd_byte
);

  logic [RING_AW-1:0] wp_r, wp_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic               hit_r;
  logic [RING_AW-1:0] rd_offset;
  logic [7:0]         ram_data;

  // writes run sequentially from the start position, so an entry holds
  // stream data exactly when its distance from the start is below the fill
  assign rd_offset = cmd.rd_addr - START_POS;

  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (cmd.wr_en) begin
      wp_nxt = wp_r + 1'b1;
      if (fill_r != FILL_FULL) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
    if (cmd.clear) begin
      wp_nxt   = START_POS;
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= START_POS;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      hit_r <= ({1'b0, rd_offset} < fill_r);
    end
  end

  lzssd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_ram (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .wr_addr (wp_r),
    .wr_data (cmd.wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (cmd.rd_addr),
    .rd_data (ram_data)
  );

  assign rd_byte = hit_r ? ram_data : 8'h00;

endmodule

// ===== src/lzss_ring_decompressor_unit.sv =====
// lzss decoder top level: token parser, copy sequencer and output register
// depends on lzssd_pkg and lzssd_ring

// Decodes an LZSS stream with a 4096-byte history ring, one compressed byte per
// input request. Flag bytes and the first byte of a match are taken in the idle
// state alone; a literal is accepted, then emitted; the second byte of a match
// starts a copy of 3 to 18 bytes, in which each copied byte is read from the
// single ring memory and then written back before the next read. A stalled
// output channel holds the emit steps. The ring needs no clearing pass: a fill
// count marks which entries the current stream wrote and the rest read as zero,
// so a new stream starts right after the final byte. Output stops at the limit in
// max_output_bytes (cfg_wr_data); the user writes it only while the block is idle,
// as the block does not enforce this. The rest of that stream is consumed silently.

module lzss_ring_decompressor_unit
  import lzssd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,   // max_output_bytes
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,      // in_byte
  input  logic             in_tlast,      // in_last
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,     // out_byte
  output logic             out_tlast,     // run_last
  output logic             out_tuser      // limit_reached
);

  state_t             state_r, state_nxt;
  phase_t             phase_r, phase_nxt;
  logic [7:0]         token_r, token_nxt;
  logic [3:0]         left_r, left_nxt;
  logic [7:0]         first_r, first_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               stopped_r, stopped_nxt;
  logic [CNT_W-1:0]   max_r, max_nxt;
  logic [7:0]         byte_r, byte_nxt;
  logic               last_r, last_nxt;
  logic [RING_AW-1:0] rd_pos_r, rd_pos_nxt;
  logic [LEN_W-1:0]   len_left_r, len_left_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [7:0]         out_byte_r, out_byte_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_limit_r, out_limit_nxt;

  ring_cmd_t          ring_cmd;
  logic [7:0]         ring_byte;

  logic               in_accept;
  logic               out_free;
  logic               stop_eff;
  logic [CNT_W-1:0]   cnt_inc;
  logic               emit_stop;
  logic               emit_last;
  logic [7:0]         emit_byte;
  logic [3:0]         left_dec;
  logic               do_clear;

  assign in_tready = (state_r == S_IDLE);
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign stop_eff  = stopped_r || (cnt_r >= max_r);
  assign cnt_inc   = cnt_r + 1'b1;
  assign emit_stop = (cnt_inc >= max_r);
  assign emit_last = (state_r == S_LIT) || (len_left_r == LEN_W'(1)) || emit_stop;
  assign emit_byte = (state_r == S_LIT) ? byte_r : ring_byte;
  assign left_dec  = (left_r != 4'd0) ? (left_r - 4'd1) : 4'd0;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    token_nxt     = token_r;
    left_nxt      = left_r;
    first_nxt     = first_r;
    cnt_nxt       = cnt_r;
    stopped_nxt   = stopped_r;
    max_nxt       = cfg_wr_en ? cfg_wr_data : max_r;
    byte_nxt      = byte_r;
    last_nxt      = last_r;
    rd_pos_nxt    = rd_pos_r;
    len_left_nxt  = len_left_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_limit_nxt = out_limit_r;
    ring_cmd      = '0;
    do_clear      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_accept) begin
          last_nxt = in_tlast;
          do_clear = in_tlast;
          if (stop_eff) begin
            stopped_nxt = 1'b1;
          end else begin
            unique case (phase_r)
              PH_FLAG: begin
                token_nxt = in_tdata;
                left_nxt  = TOKEN_COUNT;
                phase_nxt = PH_DATA;
              end
              PH_DATA: begin
                if (token_r[7]) begin
                  byte_nxt  = in_tdata;
                  state_nxt = S_LIT;
                  do_clear  = 1'b0;
                end else begin
                  first_nxt = in_tdata;
                  phase_nxt = PH_MATCH2;
                end
              end
              PH_MATCH2: begin
                rd_pos_nxt   = {first_r[7:4], in_tdata};
                len_left_nxt = LEN_W'(first_r[3:0]) + LEN_BIAS;
                state_nxt    = S_RD;
                do_clear     = 1'b0;
              end
              default: begin
                phase_nxt = PH_FLAG;
              end
            endcase
          end
        end
      end
      S_RD: begin
        ring_cmd.rd_en   = 1'b1;
        ring_cmd.rd_addr = rd_pos_r;
        state_nxt        = S_WR;
      end
      S_LIT, S_WR: begin
        if (out_free) begin
          ring_cmd.wr_en   = 1'b1;
          ring_cmd.wr_data = emit_byte;
          out_valid_nxt    = 1'b1;
          out_byte_nxt     = emit_byte;
          out_last_nxt     = emit_last;
          out_limit_nxt    = (cnt_inc == max_r);
          cnt_nxt          = cnt_inc;
          if (emit_stop) begin
            stopped_nxt = 1'b1;
          end
          if (emit_last) begin
            // token done: move to the next flag bit
            token_nxt = {token_r[6:0], 1'b0};
            left_nxt  = left_dec;
            phase_nxt = (left_dec == 4'd0) ? PH_FLAG : PH_DATA;
            state_nxt = S_IDLE;
            do_clear  = last_r;
          end else begin
            rd_pos_nxt   = rd_pos_r + 1'b1;
            len_left_nxt = len_left_r - 1'b1;
            state_nxt    = S_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // end of stream: parser state, output count, stop flag and ring return to reset; the limit is kept
    if (do_clear) begin
      phase_nxt      = PH_FLAG;
      token_nxt      = '0;
      left_nxt       = '0;
      first_nxt      = '0;
      cnt_nxt        = '0;
      stopped_nxt    = 1'b0;
      ring_cmd.clear = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FLAG;
      token_r     <= '0;
      left_r      <= '0;
      first_r     <= '0;
      cnt_r       <= '0;
      stopped_r   <= 1'b0;
      max_r       <= MAX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      token_r     <= token_nxt;
      left_r      <= left_nxt;
      first_r     <= first_nxt;
      cnt_r       <= cnt_nxt;
      stopped_r   <= stopped_nxt;
      max_r       <= max_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r      <= byte_nxt;
    last_r      <= last_nxt;
    rd_pos_r    <= rd_pos_nxt;
    len_left_r  <= len_left_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
    out_limit_r <= out_limit_nxt;
  end

  lzssd_ring u_ring (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (ring_cmd),
    .rd_byte (ring_byte)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_limit_r;

  a_copy_has_bytes : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WR) |-> (len_left_r != '0))
    else $error("copy step with no bytes left");

  a_read_then_write : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |=> (state_r == S_WR))
    else $error("ring read not followed by its write step");

  a_copy_below_limit : assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RD) |-> (cnt_r < max_r))
    else $error("copy continues past the output limit");

endmodule
